FILE: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; define ASSERT_OFF to drop them.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that cond implies prop in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Check that cond implies prop in the cycle after.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: rtl/car_pkg.sv
// -----------------------------------------------------------------------------
// Autorange controller package
// Sizes, codes and limit constants shared by the controller and its interfaces.
// -----------------------------------------------------------------------------
package car_pkg;

    localparam int NUM_RANGES = 10;
    localparam int ADC_BITS   = 16;

    localparam int CODE_PORT_W = 16;
    localparam int RANGE_W     = 4;
    localparam int DRIVE_W     = NUM_RANGES;
    localparam int CODE_W      = (ADC_BITS < CODE_PORT_W) ? ADC_BITS : CODE_PORT_W;
    localparam int WIN_W       = ADC_BITS + 1;
    localparam int LIM_W       = ADC_BITS + 18;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int BIAS_W      = 15;

    localparam logic [RANGE_W-1:0] RANGE_MAX = RANGE_W'(NUM_RANGES);

    localparam longint WIN_LO_VAL = (longint'(32'h7900) << ADC_BITS) >>> 16;
    localparam longint WIN_HI_VAL = (longint'(32'h8800) << ADC_BITS) >>> 16;
    localparam logic [WIN_W-1:0] WIN_LO = WIN_W'(WIN_LO_VAL);
    localparam logic [WIN_W-1:0] WIN_HI = WIN_W'(WIN_HI_VAL);

    localparam longint FULL_SCALE = (longint'(1) << ADC_BITS) - 1;
    localparam logic signed [LIM_W-1:0] CODE_SCALE   = LIM_W'(30000);
    localparam logic signed [LIM_W-1:0] HI_OFFSET    = LIM_W'(27000);
    localparam logic signed [LIM_W-1:0] LO_OFFSET    = LIM_W'(3000);
    localparam logic signed [LIM_W-1:0] HI_LIM_RESET = LIM_W'(27000 * FULL_SCALE);
    localparam logic signed [LIM_W-1:0] LO_LIM_RESET = LIM_W'(3000 * FULL_SCALE);

    localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = RANGE_W'(10);

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_NONE   = 2'd0,
        STATUS_CONT   = 2'd1,
        STATUS_LOCKED = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AUTO_ENABLE  = 2'd0,
        CFG_BIAS_MV      = 2'd1,
        CFG_MAX_RANGE    = 2'd2,
        CFG_ORIGIN_RANGE = 2'd3
    } cfg_index_t;

    function automatic logic [DRIVE_W-1:0] drive_of(input logic [RANGE_W-1:0] r);
        logic [DRIVE_W-1:0] d;
        d = '0;
        for (int k = 1; k <= NUM_RANGES; k++)
        begin
            if (r == RANGE_W'(k))
            begin
                d[k-1] = 1'b1;
            end
        end
        return d;
    endfunction

endpackage

FILE: rtl/car_ifs.sv
// -----------------------------------------------------------------------------
// Autorange controller channels
// Valid/ready stream interfaces for samples and results.
// -----------------------------------------------------------------------------
interface car_in_if;
    logic                          valid;
    logic                          ready;
    car_pkg::op_t                  op;
    logic [car_pkg::CODE_PORT_W-1:0] adc_code;
    logic [car_pkg::RANGE_W-1:0]   range_value;

    modport source (output valid, output op, output adc_code, output range_value,
                    input ready);
    modport sink   (input valid, input op, input adc_code, input range_value,
                    output ready);
endinterface

interface car_out_if;
    logic                        valid;
    logic                        ready;
    logic                        retry;
    logic [car_pkg::RANGE_W-1:0] active_range;
    logic [car_pkg::DRIVE_W-1:0] relay_drive;
    car_pkg::status_t            change_status;

    modport source (output valid, output retry, output active_range,
                    output relay_drive, output change_status, input ready);
    modport sink   (input valid, input retry, input active_range,
                    input relay_drive, input change_status, output ready);
endinterface

FILE: rtl/current_autorange_controller.sv
// -----------------------------------------------------------------------------
// Current autorange controller
// An accepted sample is registered at input; its result is registered at the output.
// Throughput: one per cycle unless output stalls; single compare-and-update stage.
// A stalled output holds the result register; the input register holds behind it.
// Reset clears range (no relay), lock, valids and restores register defaults.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module current_autorange_controller
(
    input  logic                               clk,
    input  logic                               rst_n,
    car_in_if.sink                             sample_in,
    car_out_if.source                          result_out,
    input  logic                               cfg_we,
    input  logic [car_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [car_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int LW = car_pkg::LIM_W;
    localparam int RW = car_pkg::RANGE_W;

    logic                       auto_enable_reg;
    logic [RW-1:0]              max_range_reg;
    logic [RW-1:0]              origin_range_reg;
    logic signed [LW-1:0]       hi_lim_reg;
    logic signed [LW-1:0]       lo_lim_reg;

    logic                       s1_valid_reg;
    car_pkg::op_t               s1_op_reg;
    logic [car_pkg::CODE_W-1:0] s1_code_reg;
    logic [RW-1:0]              s1_range_reg;

    logic [RW-1:0]              range_now_reg;
    logic                       locked_reg;

    logic                       out_valid_reg;
    logic                       retry_reg;
    logic [RW-1:0]              active_range_reg;
    logic [car_pkg::DRIVE_W-1:0] relay_drive_reg;
    car_pkg::status_t           status_reg;

    logic                       advance;
    logic                       accept;

    logic signed [LW-1:0]       bias_ext;
    logic signed [LW-1:0]       hi_term;
    logic signed [LW-1:0]       lo_term;
    logic signed [LW-1:0]       code_ext;
    logic signed [LW-1:0]       lhs;
    logic [car_pkg::WIN_W-1:0]  code_win;
    logic                       over;
    logic                       near_zero;
    logic [RW-1:0]              top;
    logic [RW-1:0]              range_dn;
    logic [RW-1:0]              range_up;

    logic [RW-1:0]              range_next;
    logic                       locked_next;
    logic                       retry_next;
    car_pkg::status_t           status_next;

    assign advance         = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign sample_in.ready = !s1_valid_reg || advance;
    assign accept          = sample_in.valid && sample_in.ready;

    assign bias_ext = LW'($signed(cfg_wdata[car_pkg::BIAS_W-1:0]));
    assign hi_term  = car_pkg::HI_OFFSET - bias_ext;
    assign lo_term  = car_pkg::LO_OFFSET - bias_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_enable_reg  <= 1'b0;
            max_range_reg    <= car_pkg::MAX_RANGE_RESET;
            origin_range_reg <= '0;
            hi_lim_reg       <= car_pkg::HI_LIM_RESET;
            lo_lim_reg       <= car_pkg::LO_LIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                car_pkg::CFG_AUTO_ENABLE:
                begin
                    auto_enable_reg <= cfg_wdata[0];
                end
                car_pkg::CFG_BIAS_MV:
                begin
                    hi_lim_reg <= (hi_term <<< car_pkg::ADC_BITS) - hi_term;
                    lo_lim_reg <= (lo_term <<< car_pkg::ADC_BITS) - lo_term;
                end
                car_pkg::CFG_MAX_RANGE:
                begin
                    max_range_reg <= cfg_wdata[RW-1:0];
                end
                car_pkg::CFG_ORIGIN_RANGE:
                begin
                    origin_range_reg <= cfg_wdata[RW-1:0];
                end
                default:
                begin
                    auto_enable_reg <= auto_enable_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            s1_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= sample_in.op;
            s1_code_reg  <= sample_in.adc_code[car_pkg::CODE_W-1:0];
            s1_range_reg <= sample_in.range_value;
        end
    end

    assign code_ext  = LW'(s1_code_reg);
    assign lhs       = code_ext * car_pkg::CODE_SCALE;
    assign over      = (lhs > hi_lim_reg) || (lhs < lo_lim_reg);
    assign code_win  = car_pkg::WIN_W'(s1_code_reg);
    assign near_zero = (code_win >= car_pkg::WIN_LO) && (code_win < car_pkg::WIN_HI);
    assign top       = (max_range_reg > car_pkg::RANGE_MAX) ? car_pkg::RANGE_MAX
                                                            : max_range_reg;
    assign range_dn  = range_now_reg - RW'(1);
    assign range_up  = range_now_reg + RW'(1);

    always_comb
    begin
        range_next  = range_now_reg;
        locked_next = locked_reg;
        retry_next  = 1'b0;
        status_next = car_pkg::STATUS_NONE;
        case (s1_op_reg)
            car_pkg::OP_LOAD:
            begin
                range_next  = (s1_range_reg > car_pkg::RANGE_MAX) ? car_pkg::RANGE_MAX
                                                                  : s1_range_reg;
                retry_next  = (range_next != range_now_reg);
                locked_next = 1'b0;
            end
            car_pkg::OP_SAMPLE:
            begin
                if (auto_enable_reg && !locked_reg)
                begin
                    if (over)
                    begin
                        if (range_now_reg > RW'(1))
                        begin
                            range_next = range_dn;
                            retry_next = 1'b1;
                            if (range_dn == origin_range_reg)
                            begin
                                status_next = car_pkg::STATUS_LOCKED;
                                locked_next = 1'b1;
                            end
                            else
                            begin
                                status_next = car_pkg::STATUS_CONT;
                            end
                        end
                    end
                    else if (near_zero && (range_now_reg < top))
                    begin
                        retry_next = 1'b1;
                        if (range_up == origin_range_reg)
                        begin
                            status_next = car_pkg::STATUS_LOCKED;
                            locked_next = 1'b1;
                        end
                        else
                        begin
                            range_next  = range_up;
                            status_next = car_pkg::STATUS_CONT;
                        end
                    end
                end
            end
            default:
            begin
                range_next = range_now_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_now_reg <= '0;
            locked_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                range_now_reg <= range_next;
                locked_reg    <= locked_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            retry_reg        <= retry_next;
            active_range_reg <= range_next;
            relay_drive_reg  <= car_pkg::drive_of(range_next);
            status_reg       <= status_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.retry         = retry_reg;
    assign result_out.active_range  = active_range_reg;
    assign result_out.relay_drive   = relay_drive_reg;
    assign result_out.change_status = status_reg;

    `ASSERT_IMPLIES(a_drive_onehot, clk, rst_n, out_valid_reg, $onehot0(relay_drive_reg))
    `ASSERT_IMPLIES(a_lock_retry, clk, rst_n, out_valid_reg && status_reg == car_pkg::STATUS_LOCKED, retry_reg)
    `ASSERT_NEXT(a_load_unlocks, clk, rst_n, advance && s1_op_reg == car_pkg::OP_LOAD, !locked_reg)
    `ASSERT_IMPLIES(a_range_bound, clk, rst_n, 1'b1, range_now_reg <= car_pkg::RANGE_MAX)

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Current autorange controller testbench
// Drives sample and load transactions into the controller under a series of
// register settings. Both channel sides idle at random. An in-bench model of
// the range stepping, lock and fallback rules predicts each result. Every
// result transaction is compared field by field against the oldest prediction.
// -----------------------------------------------------------------------------
module tb_top;

    localparam longint CODE_FULL  = 65535;
    localparam int     NEAR_LO    = 16'h7900;
    localparam int     NEAR_HI    = 16'h8800;
    localparam int     IDLE_PCT   = 19;

    typedef struct {
        logic                          retry;
        logic [car_pkg::RANGE_W-1:0]   active_range;
        logic [car_pkg::DRIVE_W-1:0]   relay_drive;
        car_pkg::status_t              change_status;
    } range_step_t;

    class range_scoreboard;
        logic               auto_on;
        int                 bias;
        logic [3:0]         max_rng;
        logic [3:0]         origin;
        logic [3:0]         range_now;
        logic               is_locked;
        range_step_t        expected_steps[$];
        int                 mismatches;

        function new();
            auto_on    = 1'b0;
            bias       = 0;
            max_rng    = 4'd10;
            origin     = 4'd0;
            range_now  = 4'd0;
            is_locked  = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(car_pkg::cfg_index_t idx, logic [car_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                car_pkg::CFG_AUTO_ENABLE:  auto_on = d[0];
                car_pkg::CFG_BIAS_MV:      bias = int'($signed(d));
                car_pkg::CFG_MAX_RANGE:    max_rng = d[3:0];
                car_pkg::CFG_ORIGIN_RANGE: origin = d[3:0];
                default:                   ;
            endcase
        endfunction

        function logic [car_pkg::DRIVE_W-1:0] relay_for(logic [3:0] r);
            if (r >= 1 && r <= car_pkg::NUM_RANGES)
            begin
                return car_pkg::DRIVE_W'(1) << (r - 1);
            end
            return '0;
        endfunction

        function void note_sample(car_pkg::op_t op, logic [15:0] code, logic [3:0] rv);
            range_step_t step;
            logic [3:0]  top;
            logic [3:0]  load_rng;
            longint      lhs;
            logic        over;
            step.retry         = 1'b0;
            step.change_status = car_pkg::STATUS_NONE;
            if (op == car_pkg::OP_LOAD)
            begin
                load_rng   = (rv > car_pkg::NUM_RANGES) ? 4'(car_pkg::NUM_RANGES) : rv;
                step.retry = (load_rng != range_now);
                range_now  = load_rng;
                is_locked  = 1'b0;
            end
            else if (auto_on && !is_locked)
            begin
                lhs  = longint'(code) * 30000;
                over = (lhs > (27000 - longint'(bias)) * CODE_FULL) ||
                       (lhs < (3000 - longint'(bias)) * CODE_FULL);
                top  = (max_rng > car_pkg::NUM_RANGES) ? 4'(car_pkg::NUM_RANGES) : max_rng;
                if (over)
                begin
                    if (range_now > 4'd1)
                    begin
                        range_now = range_now - 4'd1;
                        if (range_now == origin)
                        begin
                            step.change_status = car_pkg::STATUS_LOCKED;
                            is_locked = 1'b1;
                        end
                        else
                        begin
                            step.change_status = car_pkg::STATUS_CONT;
                        end
                        step.retry = 1'b1;
                    end
                end
                else if (code >= NEAR_LO && code < NEAR_HI)
                begin
                    if (range_now < top)
                    begin
                        range_now = range_now + 4'd1;
                        if (range_now == origin)
                        begin
                            range_now = range_now - 4'd1;
                            step.change_status = car_pkg::STATUS_LOCKED;
                            is_locked = 1'b1;
                        end
                        else
                        begin
                            step.change_status = car_pkg::STATUS_CONT;
                        end
                        step.retry = 1'b1;
                    end
                end
            end
            step.active_range = range_now;
            step.relay_drive  = relay_for(range_now);
            expected_steps.push_back(step);
        endfunction

        function void check_result(logic retry, logic [car_pkg::RANGE_W-1:0] rng,
                                   logic [car_pkg::DRIVE_W-1:0] drive,
                                   car_pkg::status_t status);
            range_step_t exp_step;
            if (expected_steps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: unexpected result retry=%0b range=%0d drive=%b status=%0d",
                             retry, rng, drive, status);
                end
                return;
            end
            exp_step = expected_steps.pop_front();
            if (retry !== exp_step.retry || rng !== exp_step.active_range ||
                drive !== exp_step.relay_drive || status !== exp_step.change_status)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at %0t: retry %0b/%0b range %0d/%0d drive %b/%b status %0d/%0d",
                             $realtime, exp_step.retry, retry, exp_step.active_range, rng,
                             exp_step.relay_drive, drive, exp_step.change_status, status);
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [car_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [car_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                            idle_on;

    car_in_if  in_if();
    car_out_if out_if();

    range_scoreboard sb = new();

    current_autorange_controller uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (in_if),
        .result_out (out_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        out_if.ready <= rst_n && !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
            begin
                sb.note_sample(in_if.op, in_if.adc_code, in_if.range_value);
            end
            if (out_if.valid && out_if.ready)
            begin
                sb.check_result(out_if.retry, out_if.active_range, out_if.relay_drive,
                                out_if.change_status);
            end
        end
    end

    task automatic send_item(input car_pkg::op_t op, input logic [15:0] code,
                             input logic [3:0] rv);
        if (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.adc_code    <= code;
        in_if.range_value <= rv;
        do
            @(posedge clk);
        while (!in_if.ready);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_steps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input car_pkg::cfg_index_t idx,
                             input logic [car_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic auto_on, input int bias, input int maxr,
                                 input int origin);
        write_reg(car_pkg::CFG_AUTO_ENABLE, car_pkg::CFG_DATA_W'(auto_on));
        write_reg(car_pkg::CFG_BIAS_MV, car_pkg::CFG_DATA_W'(bias));
        write_reg(car_pkg::CFG_MAX_RANGE, car_pkg::CFG_DATA_W'(maxr));
        write_reg(car_pkg::CFG_ORIGIN_RANGE, car_pkg::CFG_DATA_W'(origin));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] clamp_code(longint v);
        if (v < 0)
        begin
            return 16'd0;
        end
        if (v > CODE_FULL)
        begin
            return 16'hFFFF;
        end
        return 16'(v);
    endfunction

    function automatic logic [15:0] pick_code();
        longint hi_edge;
        longint lo_edge;
        int     roll;
        hi_edge = ((27000 - longint'(sb.bias)) * CODE_FULL) / 30000;
        lo_edge = ((3000 - longint'(sb.bias)) * CODE_FULL) / 30000;
        roll    = $urandom_range(99);
        if (roll < 30)
        begin
            return 16'($urandom_range(NEAR_HI - 1, NEAR_LO));
        end
        else if (roll < 44)
        begin
            return clamp_code(hi_edge + $urandom_range(4000));
        end
        else if (roll < 58)
        begin
            return clamp_code(lo_edge - $urandom_range(4000));
        end
        else if (roll < 74)
        begin
            case ($urandom_range(3))
                0:       return clamp_code(hi_edge + $urandom_range(4) - 2);
                1:       return clamp_code(lo_edge + $urandom_range(4) - 2);
                2:       return 16'($urandom_range(NEAR_LO, NEAR_LO - 1));
                default: return 16'($urandom_range(NEAR_HI, NEAR_HI - 1));
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic random_items(input int count, input bit pause_midway);
        logic [3:0] rv;
        int         load_pct;
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
            begin
                drain();
            end
            load_pct = sb.is_locked ? 35 : 6;
            rv = ($urandom_range(99) < 15) ? 4'($urandom_range(15, 11))
                                           : 4'($urandom_range(10));
            if ($urandom_range(99) < load_pct)
            begin
                send_item(car_pkg::OP_LOAD, 16'($urandom), rv);
            end
            else
            begin
                send_item(car_pkg::OP_SAMPLE, pick_code(), rv);
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        idle_on           = 1'b1;
        cfg_we            = 1'b0;
        cfg_index         = car_pkg::CFG_AUTO_ENABLE;
        cfg_wdata         = '0;
        in_if.valid       = 1'b0;
        in_if.op          = car_pkg::OP_SAMPLE;
        in_if.adc_code    = '0;
        in_if.range_value = '0;
        out_if.ready      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(car_pkg::OP_SAMPLE, 16'hFFFF, 4'd0);
        send_item(car_pkg::OP_LOAD, 16'h0000, 4'd5);
        send_item(car_pkg::OP_SAMPLE, 16'h8000, 4'd0);
        drain();
        apply_setting(1'b1, 0, 10, 0);
        send_item(car_pkg::OP_LOAD, 16'h1234, 4'd15);
        send_item(car_pkg::OP_LOAD, 16'h0000, 4'd10);
        send_item(car_pkg::OP_SAMPLE, 16'h8000, 4'd0);
        send_item(car_pkg::OP_LOAD, 16'h0000, 4'd5);
        send_item(car_pkg::OP_SAMPLE, 16'h7900, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'h87FF, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'h8800, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'h78FF, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'hFFFF, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'h0000, 4'd0);
        send_item(car_pkg::OP_LOAD, 16'h0000, 4'd1);
        send_item(car_pkg::OP_SAMPLE, 16'hFFFF, 4'd0);
        send_item(car_pkg::OP_LOAD, 16'h0000, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'h0000, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'h8000, 4'd0);
        drain();
        apply_setting(1'b1, 0, 15, 3);
        send_item(car_pkg::OP_LOAD, 16'h0000, 4'd5);
        send_item(car_pkg::OP_SAMPLE, 16'hFFFF, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'hFFFF, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'hFFFF, 4'd0);
        send_item(car_pkg::OP_LOAD, 16'h0000, 4'd1);
        send_item(car_pkg::OP_SAMPLE, 16'h8000, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'h8000, 4'd0);
        send_item(car_pkg::OP_SAMPLE, 16'h8000, 4'd0);
        drain();

        apply_setting(1'b1, 0, 10, 0);
        random_items(130, 1'b0);
        drain();
        apply_setting(1'b1, 12000, 10, 5);
        random_items(130, 1'b0);
        drain();
        idle_on = 1'b0;
        apply_setting(1'b1, -12000, 10, 10);
        random_items(130, 1'b0);
        drain();
        idle_on = 1'b1;
        apply_setting(1'b1, 3000, 1, 1);
        random_items(130, 1'b0);
        drain();
        apply_setting(1'b1, -500, 15, 7);
        random_items(130, 1'b0);
        drain();
        apply_setting(1'b0, 7000, 6, 3);
        random_items(120, 1'b0);
        drain();
        apply_setting(1'b1, -7777, 6, 2);
        random_items(130, 1'b1);
        drain();
        apply_setting(1'b1, 11999, 10, 0);
        random_items(120, 1'b0);
        drain();

        if (sb.mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/car_pkg.sv
rtl/car_ifs.sv
rtl/current_autorange_controller.sv
tb/sv/tb_top.sv
